[rtl/anh_pkg.sv]
// Package for the archive name hash block: constants, snapshot type and
// helper functions shared by the accumulate and finish stages.
// No dependencies.
package anh_pkg;

  localparam logic [7:0]  BACKSLASH     = 8'h5C;
  localparam logic [7:0]  DOT           = 8'h2E;
  localparam int unsigned STEM_LIMIT    = 260;
  localparam logic [4:0]  EXT_LIMIT     = 5'd16;
  localparam logic [4:0]  EXT_COUNT_MAX = 5'd31;
  localparam int unsigned NUM_EXT       = 6;

  // Known extensions, first byte lowest; entry 0 is the empty extension
  localparam logic [31:0] KNOWN_EXT [NUM_EXT] = '{
    32'h0000_0000,  // empty
    32'h6669_6E2E,  // .nif
    32'h0066_6B2E,  // .kf
    32'h7364_642E,  // .dds
    32'h7661_772E,  // .wav
    32'h7064_612E   // .adp
  };

  // Values picked at the end of a name, handed to the finish stage
  typedef struct packed {
    logic        kind;
    logic [7:0]  first;
    logic [7:0]  last;
    logic [7:0]  last2;
    logic [31:0] sum;
    logic [31:0] ext_sum;
    logic [4:0]  ext_count;
    logic [31:0] ext_word;
  } snap_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } ext_match_t;

  // s * 0x1003F + b, as shifts and adds (0x1003F = 2^16 + 2^6 - 1)
  function automatic logic [31:0] hash_step(input logic [31:0] s, input logic [7:0] b);
    hash_step = (s << 16) + (s << 6) - s + {24'd0, b};
  endfunction

  // Lowest table entry equal to the extension word
  function automatic ext_match_t ext_lookup(input logic [31:0] word);
    ext_match_t m;
    m = '0;
    for (int k = NUM_EXT - 1; k >= 0; k--) begin
      if (KNOWN_EXT[k] == word) begin
        m.hit = 1'b1;
        m.idx = 3'(k);
      end
    end
    return m;
  endfunction

endpackage

[rtl/anh_in_if.sv]
// Input channel of the archive name hash: one name byte per beat.
// No dependencies.
interface anh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       kind;
  logic       end_of_name;
  logic       no_byte;

  modport source (output valid, output name_byte, output kind, output end_of_name,
                  output no_byte, input ready);
  modport sink   (input valid, input name_byte, input kind, input end_of_name,
                  input no_byte, output ready);
endinterface

[rtl/anh_out_if.sv]
// Output channel of the archive name hash: one hash result per beat.
// No dependencies.
interface anh_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  hash_first;
  logic [7:0]  hash_last;
  logic [7:0]  hash_last2;
  logic [7:0]  hash_length;
  logic [31:0] hash_sum;
  logic        rejected;

  modport source (output valid, output hash_first, output hash_last, output hash_last2,
                  output hash_length, output hash_sum, output rejected, input ready);
  modport sink   (input valid, input hash_first, input hash_last, input hash_last2,
                  input hash_length, input hash_sum, input rejected, output ready);
endinterface

[rtl/anh_accum.sv]
// Accumulate stage: running prefix, stem and extension state, one byte per
// beat, and the snapshot register loaded at the end of each name.
// Depends on anh_pkg and anh_in_if.
module anh_accum #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  anh_in_if.sink                name_ch,
  output logic                  snap_valid,
  input  logic                  snap_ready,
  output anh_pkg::snap_t        snap,
  output logic [COUNT_BITS-1:0] snap_count
);
  import anh_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // running state
  logic [COUNT_BITS-1:0] prefix_count, prefix_count_next;
  logic [7:0]            prefix_first, prefix_first_next;
  logic [7:0]            prev_byte, prev_byte_next;
  logic [7:0]            prev2_byte, prev2_byte_next;
  logic [31:0]           prefix_sum, prefix_sum_next;
  logic [COUNT_BITS-1:0] stem_count, stem_count_next;
  logic [7:0]            stem_first, stem_first_next;
  logic [7:0]            stem_last, stem_last_next;
  logic [7:0]            stem_last2, stem_last2_next;
  logic [31:0]           stem_sum, stem_sum_next;
  logic                  dot_seen, dot_seen_next;
  logic [31:0]           ext_sum, ext_sum_next;
  logic [4:0]            ext_count, ext_count_next;
  logic [31:0]           ext_word, ext_word_next;

  logic  accept;
  logic  has_byte;
  logic  is_bs;
  logic  is_dot;
  logic  use_stem;
  snap_t snap_next;
  logic [COUNT_BITS-1:0] snap_count_next;

  assign name_ch.ready = !snap_valid || snap_ready;
  assign accept        = name_ch.valid && name_ch.ready;
  assign has_byte      = !name_ch.no_byte;
  assign is_bs         = name_ch.kind && (name_ch.name_byte == BACKSLASH);
  assign is_dot        = name_ch.kind && (name_ch.name_byte == DOT);

  // next state for one byte
  always_comb begin
    prefix_count_next = prefix_count;
    prefix_first_next = prefix_first;
    prev_byte_next    = prev_byte;
    prev2_byte_next   = prev2_byte;
    prefix_sum_next   = prefix_sum;
    stem_count_next   = stem_count;
    stem_first_next   = stem_first;
    stem_last_next    = stem_last;
    stem_last2_next   = stem_last2;
    stem_sum_next     = stem_sum;
    dot_seen_next     = dot_seen;
    ext_sum_next      = ext_sum;
    ext_count_next    = ext_count;
    ext_word_next     = ext_word;
    if (has_byte) begin
      if (is_bs) begin
        // backslash drops everything before it
        prefix_count_next = '0;
        prefix_first_next = '0;
        prev_byte_next    = '0;
        prev2_byte_next   = '0;
        prefix_sum_next   = '0;
        stem_count_next   = '0;
        stem_first_next   = '0;
        stem_last_next    = '0;
        stem_last2_next   = '0;
        stem_sum_next     = '0;
        dot_seen_next     = 1'b0;
        ext_sum_next      = '0;
        ext_count_next    = '0;
        ext_word_next     = '0;
      end else begin
        if (is_dot) begin
          // stem is the prefix so far; extension restarts with the dot
          stem_count_next = prefix_count;
          stem_first_next = prefix_first;
          stem_last_next  = prev_byte;
          stem_last2_next = prev2_byte;
          stem_sum_next   = prefix_sum;
          dot_seen_next   = 1'b1;
          ext_word_next   = {24'd0, name_ch.name_byte};
          ext_sum_next    = {24'd0, name_ch.name_byte};
          ext_count_next  = 5'd1;
        end else if (name_ch.kind && dot_seen) begin
          if (ext_count[4:2] == 3'd0) begin
            ext_word_next = ext_word |
                            ({24'd0, name_ch.name_byte} << {ext_count[1:0], 3'b000});
          end
          ext_sum_next = hash_step(ext_sum, name_ch.name_byte);
          if (ext_count != EXT_COUNT_MAX) begin
            ext_count_next = ext_count + 5'd1;
          end
        end
        // prefix takes every byte other than a backslash
        if (prefix_count == '0) begin
          prefix_first_next = name_ch.name_byte;
        end
        if (prefix_count >= COUNT_BITS'(3)) begin
          prefix_sum_next = hash_step(prefix_sum, prev2_byte);
        end
        prev2_byte_next = prev_byte;
        prev_byte_next  = name_ch.name_byte;
        if (prefix_count != COUNT_MAX) begin
          prefix_count_next = prefix_count + COUNT_BITS'(1);
        end
      end
    end
  end

  // pick prefix or stem at the end of the name
  always_comb begin
    use_stem       = name_ch.kind && dot_seen_next;
    snap_next.kind = name_ch.kind;
    if (use_stem) begin
      snap_count_next     = stem_count_next;
      snap_next.first     = stem_first_next;
      snap_next.last      = stem_last_next;
      snap_next.last2     = stem_last2_next;
      snap_next.sum       = stem_sum_next;
      snap_next.ext_sum   = ext_sum_next;
      snap_next.ext_count = ext_count_next;
      snap_next.ext_word  = ext_word_next;
    end else begin
      snap_count_next     = prefix_count_next;
      snap_next.first     = prefix_first_next;
      snap_next.last      = prev_byte_next;
      snap_next.last2     = prev2_byte_next;
      snap_next.sum       = prefix_sum_next;
      snap_next.ext_sum   = '0;
      snap_next.ext_count = '0;
      snap_next.ext_word  = '0;
    end
  end

  // state registers; cleared after each name
  always_ff @(posedge clk) begin
    if (rst || (accept && name_ch.end_of_name)) begin
      prefix_count <= '0;
      prefix_first <= '0;
      prev_byte    <= '0;
      prev2_byte   <= '0;
      prefix_sum   <= '0;
      stem_count   <= '0;
      stem_first   <= '0;
      stem_last    <= '0;
      stem_last2   <= '0;
      stem_sum     <= '0;
      dot_seen     <= 1'b0;
      ext_sum      <= '0;
      ext_count    <= '0;
      ext_word     <= '0;
    end else if (accept) begin
      prefix_count <= prefix_count_next;
      prefix_first <= prefix_first_next;
      prev_byte    <= prev_byte_next;
      prev2_byte   <= prev2_byte_next;
      prefix_sum   <= prefix_sum_next;
      stem_count   <= stem_count_next;
      stem_first   <= stem_first_next;
      stem_last    <= stem_last_next;
      stem_last2   <= stem_last2_next;
      stem_sum     <= stem_sum_next;
      dot_seen     <= dot_seen_next;
      ext_sum      <= ext_sum_next;
      ext_count    <= ext_count_next;
      ext_word     <= ext_word_next;
    end
  end

  // snapshot register
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && name_ch.end_of_name) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && name_ch.end_of_name) begin
      snap       <= snap_next;
      snap_count <= snap_count_next;
    end
  end

endmodule

[rtl/anh_finish.sv]
// Finish stage: limit checks, short-name rules, extension adjust and the
// output register that drives the result channel.
// Depends on anh_pkg and anh_out_if.
module anh_finish #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  snap_valid,
  output logic                  snap_ready,
  input  anh_pkg::snap_t        snap,
  input  logic [COUNT_BITS-1:0] snap_count,
  anh_out_if.source             hash_ch
);
  import anh_pkg::*;

  logic       take;
  logic       reject;
  ext_match_t ext_m;
  logic [7:0] first_v, last_v, last2_v, length_v;
  logic [31:0] sum_v;
  logic [7:0] first_r, last_r, last2_r, length_r;
  logic [31:0] sum_r;
  logic       rejected_r;
  logic       out_valid;

  assign snap_ready = !out_valid || hash_ch.ready;
  assign take       = snap_valid && snap_ready;

  // hash parts from the snapshot
  always_comb begin
    reject = snap.kind && ((snap_count == '0) ||
                           (snap_count >= COUNT_BITS'(STEM_LIMIT)) ||
                           (snap.ext_count >= EXT_LIMIT));
    ext_m    = ext_lookup(snap.ext_word);
    length_v = snap_count[7:0];
    first_v  = (snap_count != '0) ? snap.first : 8'd0;
    last_v   = (snap_count != '0) ? snap.last : 8'd0;
    last2_v  = (snap_count >= COUNT_BITS'(3)) ? snap.last2 : 8'd0;
    sum_v    = ((length_v > 8'd3) ? snap.sum : 32'd0) + snap.ext_sum;
    // known extension: index bits land on bit 7 of the byte parts
    if (snap.kind && ext_m.hit) begin
      first_v = first_v + {ext_m.idx[2], 7'd0};
      last_v  = last_v + {ext_m.idx[1], 7'd0};
      last2_v = last2_v + {ext_m.idx[0], 7'd0};
    end
    if (reject) begin
      first_v  = '0;
      last_v   = '0;
      last2_v  = '0;
      length_v = '0;
      sum_v    = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (hash_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      first_r    <= first_v;
      last_r     <= last_v;
      last2_r    <= last2_v;
      length_r   <= length_v;
      sum_r      <= sum_v;
      rejected_r <= reject;
    end
  end

  assign hash_ch.valid       = out_valid;
  assign hash_ch.hash_first  = first_r;
  assign hash_ch.hash_last   = last_r;
  assign hash_ch.hash_last2  = last2_r;
  assign hash_ch.hash_length = length_r;
  assign hash_ch.hash_sum    = sum_r;
  assign hash_ch.rejected    = rejected_r;

endmodule

[rtl/archive_name_hash.sv]
// Archive name hash, top level. Takes one name byte per beat, gives one hash per name.
// Throughput: one byte per cycle while name_ch.ready is high; back-pressure from hash_ch can hold the input.
// The result for a name is registered in the snapshot register and then in the output
// register before it shows on hash_ch; a stall on hash_ch can hold it in between.
// Reset (rst, synchronous) clears all running state and empties both stages.
// Depends on anh_pkg, anh_in_if, anh_out_if, anh_accum and anh_finish.
module archive_name_hash #(
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  anh_in_if.sink    name_ch,
  anh_out_if.source hash_ch
);
  import anh_pkg::*;

  logic                  snap_valid;
  logic                  snap_ready;
  snap_t                 snap;
  logic [COUNT_BITS-1:0] snap_count;

  anh_accum #(
    .COUNT_BITS (COUNT_BITS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .name_ch    (name_ch),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .snap_count (snap_count)
  );

  anh_finish #(
    .COUNT_BITS (COUNT_BITS)
  ) u_finish (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .snap_count (snap_count),
    .hash_ch    (hash_ch)
  );

endmodule
